@@ src/udf_pkg.sv @@
package udf_pkg;

  localparam int MAX_FIELD_DEF = 64;
  localparam int VALUE_BITS_DEF = 32;
  localparam int IN_VALUE_W = 32;

  localparam logic [7:0] CHAR_ZERO = 8'd48;
  localparam logic [7:0] CHAR_SPACE = 8'd32;

  typedef struct packed {
    logic [IN_VALUE_W-1:0] value;
    logic [6:0]            field_width;
    logic                  has_precision;
    logic [6:0]            min_digits;
    logic                  left_justify;
    logic                  zero_pad;
  } in_item_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIZE,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic conv_step;
    logic size;
    logic emit_step;
  } cmd_t;

  typedef struct packed {
    logic conv_done;
    logic empty;
    logic last;
  } sts_t;

endpackage

@@ src/udf_ctrl.sv @@
module udf_ctrl
  import udf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        if (sts_i.conv_done) begin
          state_d = ST_SIZE;
        end
      end
      ST_SIZE: begin
        state_d = sts_i.empty ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        if (out_ready_i && sts_i.last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_CONV: begin
        cmd_o.conv_step = 1'b1;
      end
      ST_SIZE: begin
        cmd_o.size = 1'b1;
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        cmd_o.emit_step = out_ready_i;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

@@ src/udf_datapath.sv @@
module udf_datapath
  import udf_pkg::*;
#(
  parameter int MAX_FIELD = MAX_FIELD_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_item_i,
  input  cmd_t      cmd_i,
  output sts_t      sts_o,
  output out_item_t out_item_o
);

  localparam int VB = (VALUE_BITS < IN_VALUE_W) ? VALUE_BITS : IN_VALUE_W;
  localparam int DIG = ((VB * 1233) >> 12) + 1;
  localparam int DW = $clog2(DIG + 1);
  localparam int IW = (DIG > 1) ? $clog2(DIG) : 1;
  localparam int LW = $clog2(MAX_FIELD + 1);
  localparam int BW = (VB > 1) ? $clog2(VB) : 1;

  logic [VB-1:0]          bin_q, bin_d;
  logic [DIG-1:0][3:0]    bcd_q, bcd_d, bcd_adj;
  logic [BW-1:0]          bit_cnt_q, bit_cnt_d;
  logic                   vzero_q;
  logic [LW-1:0]          width_q, prec_q;
  logic                   dot_q, minus_q, zero_q;

  logic [LW-1:0]          pos_q, pos_d;
  logic [IW-1:0]          didx_q, didx_d;
  logic [LW-1:0]          total_q, lead_end_q, fill_end_q, dig_end_q;

  logic [DW-1:0]          ndig_raw, ndig_c;
  logic [LW-1:0]          ndig_l, fill_c, body_c, pad_c, total_c;
  logic [LW-1:0]          lead_end_c, fill_end_c, dig_end_c;
  logic [IW-1:0]          didx_init;
  logic                   no_digits;
  logic                   in_digits;
  logic [LW-1:0]          width_c, prec_c;

  assign width_c = (in_item_i.field_width > 7'(MAX_FIELD)) ? LW'(MAX_FIELD)
                                                           : LW'(in_item_i.field_width);
  assign prec_c = (in_item_i.min_digits > 7'(MAX_FIELD)) ? LW'(MAX_FIELD)
                                                         : LW'(in_item_i.min_digits);

  // shift-add-3 step
  always_comb begin
    for (int k = 0; k < DIG; k++) begin
      bcd_adj[k] = (bcd_q[k] >= 4'd5) ? bcd_q[k] + 4'd3 : bcd_q[k];
    end
  end

  always_comb begin
    bin_d = bin_q;
    bcd_d = bcd_q;
    bit_cnt_d = bit_cnt_q;
    if (cmd_i.load) begin
      bin_d = in_item_i.value[VB-1:0];
      bcd_d = '0;
      bit_cnt_d = '0;
    end else if (cmd_i.conv_step) begin
      bcd_d = (4 * DIG)'({bcd_adj, bin_q[VB-1]});
      bin_d = bin_q << 1;
      bit_cnt_d = bit_cnt_q + BW'(1);
    end
  end

  assign sts_o.conv_done = (bit_cnt_q == BW'(VB - 1));

  // field sizing
  always_comb begin
    ndig_raw = DW'(1);
    for (int k = 1; k < DIG; k++) begin
      if (bcd_q[k] != 4'd0) begin
        ndig_raw = DW'(k + 1);
      end
    end
  end

  assign no_digits = dot_q && (prec_q == '0) && vzero_q;
  assign ndig_c = no_digits ? '0 : ndig_raw;
  assign ndig_l = LW'(ndig_c);
  assign fill_c = (dot_q && (prec_q > ndig_l)) ? prec_q - ndig_l : '0;
  assign body_c = ndig_l + fill_c;
  assign pad_c = (width_q > body_c) ? width_q - body_c : '0;
  assign total_c = pad_c + body_c;
  assign lead_end_c = minus_q ? '0 : pad_c;
  assign fill_end_c = lead_end_c + fill_c;
  assign dig_end_c = fill_end_c + ndig_l;
  assign didx_init = (ndig_c == '0) ? '0 : IW'(ndig_c - DW'(1));

  assign sts_o.empty = (total_c == '0);

  // character emission
  assign in_digits = (pos_q >= fill_end_q) && (pos_q < dig_end_q);

  always_comb begin
    pos_d = pos_q;
    didx_d = didx_q;
    if (cmd_i.size) begin
      pos_d = '0;
      didx_d = didx_init;
    end else if (cmd_i.emit_step) begin
      pos_d = pos_q + LW'(1);
      if (in_digits && (didx_q != '0)) begin
        didx_d = didx_q - IW'(1);
      end
    end
  end

  assign sts_o.last = (pos_q == total_q - LW'(1));

  always_comb begin
    out_item_o.last = sts_o.last;
    if (pos_q < lead_end_q) begin
      out_item_o.character = zero_q ? CHAR_ZERO : CHAR_SPACE;
    end else if (pos_q < fill_end_q) begin
      out_item_o.character = CHAR_ZERO;
    end else if (pos_q < dig_end_q) begin
      out_item_o.character = CHAR_ZERO + {4'd0, bcd_q[didx_q]};
    end else begin
      out_item_o.character = CHAR_SPACE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_cnt_q <= '0;
      pos_q <= '0;
      didx_q <= '0;
    end else begin
      bit_cnt_q <= bit_cnt_d;
      pos_q <= pos_d;
      didx_q <= didx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
    if (cmd_i.load) begin
      vzero_q <= (in_item_i.value[VB-1:0] == '0);
      width_q <= width_c;
      prec_q <= prec_c;
      dot_q <= in_item_i.has_precision;
      minus_q <= in_item_i.left_justify;
      zero_q <= in_item_i.zero_pad;
    end
    if (cmd_i.size) begin
      total_q <= total_c;
      lead_end_q <= lead_end_c;
      fill_end_q <= fill_end_c;
      dig_end_q <= dig_end_c;
    end
  end

endmodule

@@ src/unsigned_decimal_field_formatter_unit.sv @@
// channel  direction  handshake                   payload
// in       input      in_valid_i / in_ready_o     in_item_i  (in_item_t)
// out      output     out_valid_o / out_ready_i   out_item_o (out_item_t)
//
// one item: accept, conversion of min(VALUE_BITS, 32) bits (shift-add-3 loop,
// one bit a cycle), sizing, then one character per cycle while out_ready_i is high
// rst_ni clears the controller and counters, no clearing pass
// out stalls hold the character, in_ready_o is high only between items
module unsigned_decimal_field_formatter_unit
  import udf_pkg::*;
#(
  parameter int MAX_FIELD = MAX_FIELD_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  cmd_t cmd;
  sts_t sts;

  udf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  udf_datapath #(
    .MAX_FIELD  (MAX_FIELD),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_item_o (out_item_o)
  );

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o)
    else $error("input ready while a field is emitted");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_item_o.last |=> !out_valid_o && in_ready_o)
    else $error("output continued after last character");

  a_char_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.character == CHAR_SPACE) ||
                    ((out_item_o.character >= CHAR_ZERO) &&
                     (out_item_o.character <= CHAR_ZERO + 8'd9)))
    else $error("character outside space and digits");

endmodule
